// File: hw/rtl/i2ctt_pkg.sv
// Types and constants shared by the I2C target transaction tracker.
// Standalone package: no dependencies.
`default_nettype none

package i2ctt_pkg;

    // Address-detect status bits that count as a match
    localparam logic [7:0] ADDR_MASK = 8'hAF;

    // Reset value of the recovery threshold
    localparam logic [7:0] THRESHOLD_RESET = 8'd3;

    typedef enum logic [1:0] {
        CMD_RX_FULL   = 2'd0,
        CMD_TX_EMPTY  = 2'd1,
        CMD_TX_END    = 2'd2,
        CMD_STATUS    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ADDR = 2'd1,
        PH_RX   = 2'd2,
        PH_TX   = 2'd3
    } t_phase;

    // Result item, lowest field in the lowest bits
    typedef struct packed {
        logic [7:0] error_count;
        logic       stop_irq_enable;
        t_phase     bus_phase;
        logic       discard_byte;
        logic       auto_reset;
        logic [1:0] error_events;
        logic       ev_nack;
        logic       ev_stop;
        logic       ev_tx_ready;
        logic       ev_rx_ready;
        logic       ev_addr_match;
    } t_result;

endpackage

`default_nettype wire

// File: hw/rtl/i2c_target_transaction_tracker_top.sv
// I2C target transaction tracker: phase, addressed flag and error recovery counter.
// Depends on i2ctt_pkg for event codes, phase codes and the result layout.
// An input transaction reaches result valid through the input register, then the result register.
// Throughput: one event per cycle while the result is not stalled; the state update sits between the two registers.
// A stalled result holds the state; one more event still enters the input register.
// Reset (synchronous, active low): phase idle, not addressed, error counter 0, threshold 3.
`default_nettype none

module i2c_target_transaction_tracker_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration: recovery_threshold
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data,
    // event input
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] addr_status, [8] stop_flag, [9] nack_flag, [10] timeout_flag,
    // [11] arb_lost_flag, [15:12] zero
    input  wire logic [15:0] s_axis_tdata,
    // [1:0] cmd
    input  wire logic [1:0]  s_axis_tuser,
    // result output
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] ev_addr_match, [1] ev_rx_ready, [2] ev_tx_ready, [3] ev_stop, [4] ev_nack,
    // [6:5] error_events, [7] auto_reset, [8] discard_byte, [10:9] bus_phase,
    // [11] stop_irq_enable, [19:12] error_count, [23:20] zero
    output logic [23:0]      m_axis_tdata
);

    logic [7:0]          r_threshold;

    logic                r_in_valid;
    i2ctt_pkg::t_cmd     r_cmd;
    logic [7:0]          r_status;
    logic                r_stop;
    logic                r_nack;
    logic                r_tmo;
    logic                r_al;

    i2ctt_pkg::t_phase   r_phase;
    i2ctt_pkg::t_phase   n_phase;
    logic                r_addressed;
    logic                n_addressed;
    logic [7:0]          r_errors;
    logic [7:0]          n_errors;

    logic                r_out_valid;
    i2ctt_pkg::t_result  r_out;
    i2ctt_pkg::t_result  n_out;

    logic                c_stop;
    logic                c_nack;
    logic                c_al;
    logic                c_match;
    logic                s_accept;
    logic                advance;

    assign o_cfg_ready   = 1'b1;
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= i2ctt_pkg::THRESHOLD_RESET;
        end else if (i_cfg_valid) begin
            r_threshold <= i_cfg_data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (s_accept) begin
            r_cmd    <= i2ctt_pkg::t_cmd'(s_axis_tuser);
            r_status <= s_axis_tdata[7:0];
            r_stop   <= s_axis_tdata[8];
            r_nack   <= s_axis_tdata[9];
            r_tmo    <= s_axis_tdata[10];
            r_al     <= s_axis_tdata[11];
        end
    end

    assign c_match = !r_addressed && (r_phase == i2ctt_pkg::PH_IDLE)
                     && ((r_status & i2ctt_pkg::ADDR_MASK) != 8'd0);

    always_comb begin
        n_phase     = r_phase;
        n_addressed = r_addressed;
        n_errors    = r_errors;
        n_out       = '0;
        // drop STOP and NACK while idle and not addressed
        c_stop      = r_stop && !(!r_addressed && (r_phase == i2ctt_pkg::PH_IDLE));
        c_nack      = r_nack && !(!r_addressed && (r_phase == i2ctt_pkg::PH_IDLE));
        c_al        = r_al;
        case (r_cmd)
            i2ctt_pkg::CMD_RX_FULL: begin
                if (c_match) begin
                    n_addressed         = 1'b1;
                    n_phase             = i2ctt_pkg::PH_ADDR;
                    n_out.ev_addr_match = 1'b1;
                end
                if (n_phase == i2ctt_pkg::PH_ADDR) begin
                    n_phase            = i2ctt_pkg::PH_RX;
                    n_out.discard_byte = 1'b1;
                end else begin
                    n_out.ev_rx_ready  = 1'b1;
                end
            end
            i2ctt_pkg::CMD_TX_EMPTY: begin
                if (c_match) begin
                    n_addressed         = 1'b1;
                    n_phase             = i2ctt_pkg::PH_ADDR;
                    n_out.ev_addr_match = 1'b1;
                end
                if (n_phase == i2ctt_pkg::PH_ADDR || n_phase == i2ctt_pkg::PH_IDLE) begin
                    n_phase = i2ctt_pkg::PH_TX;
                end
                n_out.ev_tx_ready = 1'b1;
            end
            i2ctt_pkg::CMD_STATUS: begin
                if (c_stop) begin
                    n_addressed   = 1'b0;
                    n_phase       = i2ctt_pkg::PH_IDLE;
                    n_errors      = 8'd0;
                    n_out.ev_stop = 1'b1;
                end
                if (c_nack) begin
                    n_out.ev_nack = 1'b1;
                end
                if (r_tmo) begin
                    n_addressed = 1'b0;
                    n_errors    = n_errors + 8'd1;
                    if (n_errors >= r_threshold) begin
                        // auto-reset: clear all state, skip arbitration loss
                        n_phase          = i2ctt_pkg::PH_IDLE;
                        n_errors         = 8'd0;
                        n_out.auto_reset = 1'b1;
                        c_al             = 1'b0;
                    end else begin
                        n_out.error_events = n_out.error_events + 2'd1;
                    end
                end
                if (c_al) begin
                    n_addressed = 1'b0;
                    n_errors    = n_errors + 8'd1;
                    if (n_errors >= r_threshold) begin
                        n_phase          = i2ctt_pkg::PH_IDLE;
                        n_errors         = 8'd0;
                        n_out.auto_reset = 1'b1;
                    end else begin
                        n_out.error_events = n_out.error_events + 2'd1;
                    end
                end
            end
            default: begin
                // transmit end: no state change, no flag
            end
        endcase
        n_out.bus_phase       = n_phase;
        n_out.stop_irq_enable = n_addressed;
        n_out.error_count     = n_errors;
    end

    // State and result register advance together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= i2ctt_pkg::PH_IDLE;
            r_addressed <= 1'b0;
            r_errors    <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_phase     <= n_phase;
                r_addressed <= n_addressed;
                r_errors    <= n_errors;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    // Addressed always implies a non-idle phase
    a_addr_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_addressed |-> (r_phase != i2ctt_pkg::PH_IDLE))
        else $error("addressed while idle");

    // An auto-reset result carries a cleared state
    a_reset_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.auto_reset) |->
        (r_out.error_count == 8'd0 && r_out.bus_phase == i2ctt_pkg::PH_IDLE
         && !r_out.stop_irq_enable && r_out.error_events != 2'd2))
        else $error("auto-reset result with live state");

    // Stalled output freezes the tracker state
    a_stall_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=>
        ($stable(r_phase) && $stable(r_errors) && $stable(r_addressed)))
        else $error("state moved during output stall");

    // Address byte drop and data ready never both
    a_rx_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.discard_byte && r_out.ev_rx_ready))
        else $error("discard and rx ready together");

endmodule

`default_nettype wire
